>>> design/tdwq_pkg.sv
package tdwq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(MAX_RESULTS + 1);
    localparam int TASK_W      = 8;
    localparam int TIME_W      = 32;
    localparam int ENTRY_W     = TIME_W + TASK_W;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_TIME  = 2'd1;
    localparam logic [1:0] CMD_DELAY = 2'd2;
    localparam logic [1:0] CMD_UNTIL = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_PAST = 2'd1;
    localparam logic [1:0] ST_TIME = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [TASK_W-1:0] task_id;
    } entry_t;

    function automatic logic s_less(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        s_less = $signed(a) < $signed(b);
    endfunction

endpackage

>>> design/tdwq_ram.sv
module tdwq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/tick_delay_wakeup_queue.sv
// Replies: time goes IDLE, EMIT, output register; immediate delay goes IDLE, DLY, EMIT.
// Tick: each wake takes one scan of the queue memory through the single read port;
// a tick waking k tasks makes k+1 scans, and EMIT waits while the output is not free.
// Throughput: one word at a time; a new word is taken once the previous is done.
// Reset: counter zero, queue empty (valid flops cleared), no clearing pass.
module tick_delay_wakeup_queue
    import tdwq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // task_req[7:0], ticks[39:8]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // reply_task[7:0], time_value[39:8]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DLY    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             ret_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [TIME_W-1:0]      when_reg;
    logic [TASK_W-1:0]      task_reg;

    logic [QW-1:0]          scan_addr_reg;
    logic                   scan_on_reg;
    logic                   rd_pend_reg;
    logic [QW-1:0]          rd_idx_reg;
    logic                   best_v_reg;
    logic [QW-1:0]          best_idx_reg;
    entry_t                 best_reg;
    logic                   pend_v_reg;
    logic [TASK_W-1:0]      pend_task_reg;
    logic [CW-1:0]          count_reg;

    logic [TASK_W-1:0]      res_task_reg;
    logic [1:0]             res_status_reg;
    logic                   res_last_reg;

    logic                   out_v_reg;
    logic [39:0]            out_data_reg;
    logic [1:0]             out_user_reg;
    logic                   out_last_reg;

    logic                   wr_en;
    logic [QW-1:0]          wr_addr;
    entry_t                 rd_ent;
    logic [ENTRY_W-1:0]     rd_raw;
    logic                   have_free;
    logic [QW-1:0]          free_idx;
    logic                   better;
    logic                   due;
    logic                   out_free;

    tdwq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({when_reg, task_reg}),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_raw)
    );

    assign rd_ent = entry_t'(rd_raw);

    always_comb
    begin
        have_free = 1'b0;
        free_idx  = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                have_free = 1'b1;
                free_idx  = QW'(i);
            end
        end
    end

    assign wr_en   = (state_reg == S_DLY) && s_less(now_reg, when_reg) && have_free;
    assign wr_addr = free_idx;

    assign better = !best_v_reg || s_less(rd_ent.wake, best_reg.wake)
                    || (rd_ent.wake == best_reg.wake && rd_ent.task_id < best_reg.task_id);
    assign due    = best_v_reg && !s_less(now_reg, best_reg.wake)
                    && (count_reg < CW'(MAX_RESULTS));
    assign out_free = !out_v_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            now_reg       <= '0;
            valid_reg     <= '0;
            scan_on_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            best_v_reg    <= 1'b0;
            pend_v_reg    <= 1'b0;
            count_reg     <= '0;
            out_v_reg     <= 1'b0;
            scan_addr_reg <= '0;
        end
        else
        begin
            if (out_v_reg && m_axis_tready && state_reg != S_EMIT)
            begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        task_reg <= s_axis_tdata[7:0];
                        unique case (s_axis_tuser)
                            CMD_TICK:
                            begin
                                now_reg       <= now_reg + 1'b1;
                                count_reg     <= '0;
                                pend_v_reg    <= 1'b0;
                                best_v_reg    <= 1'b0;
                                scan_addr_reg <= '0;
                                scan_on_reg   <= 1'b1;
                                rd_pend_reg   <= 1'b0;
                                state_reg     <= S_SCAN;
                            end
                            CMD_TIME:
                            begin
                                res_task_reg   <= s_axis_tdata[7:0];
                                res_status_reg <= ST_TIME;
                                res_last_reg   <= 1'b1;
                                ret_reg        <= S_IDLE;
                                state_reg      <= S_EMIT;
                            end
                            CMD_DELAY:
                            begin
                                when_reg  <= now_reg + s_axis_tdata[39:8];
                                state_reg <= S_DLY;
                            end
                            CMD_UNTIL:
                            begin
                                when_reg  <= s_axis_tdata[39:8];
                                state_reg <= S_DLY;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DLY:
                begin
                    res_task_reg <= task_reg;
                    res_last_reg <= 1'b1;
                    ret_reg      <= S_IDLE;
                    if (s_less(now_reg, when_reg))
                    begin
                        if (have_free)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            state_reg           <= S_IDLE;
                        end
                        else
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_EMIT;
                        end
                    end
                    else
                    begin
                        res_status_reg <= (when_reg == now_reg) ? ST_OK : ST_PAST;
                        state_reg      <= S_EMIT;
                    end
                end
                S_SCAN:
                begin
                    rd_pend_reg <= scan_on_reg;
                    rd_idx_reg  <= scan_addr_reg;
                    if (scan_on_reg)
                    begin
                        if (scan_addr_reg == QW'(QUEUE_DEPTH - 1))
                        begin
                            scan_on_reg <= 1'b0;
                        end
                        else
                        begin
                            scan_addr_reg <= scan_addr_reg + 1'b1;
                        end
                    end
                    if (rd_pend_reg && valid_reg[rd_idx_reg] && better)
                    begin
                        best_v_reg   <= 1'b1;
                        best_idx_reg <= rd_idx_reg;
                        best_reg     <= rd_ent;
                    end
                    if (!scan_on_reg && rd_pend_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    scan_addr_reg <= '0;
                    scan_on_reg   <= 1'b1;
                    rd_pend_reg   <= 1'b0;
                    best_v_reg    <= 1'b0;
                    res_task_reg   <= pend_task_reg;
                    res_status_reg <= ST_OK;
                    if (due)
                    begin
                        valid_reg[best_idx_reg] <= 1'b0;
                        pend_v_reg    <= 1'b1;
                        pend_task_reg <= best_reg.task_id;
                        count_reg     <= count_reg + 1'b1;
                        res_last_reg  <= 1'b0;
                        ret_reg       <= S_SCAN;
                        state_reg     <= pend_v_reg ? S_EMIT : S_SCAN;
                    end
                    else
                    begin
                        scan_on_reg  <= 1'b0;
                        res_last_reg <= 1'b1;
                        ret_reg      <= S_IDLE;
                        state_reg    <= pend_v_reg ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_v_reg    <= 1'b1;
                        out_data_reg <= {now_reg, res_task_reg};
                        out_user_reg <= res_status_reg;
                        out_last_reg <= res_last_reg;
                        state_reg    <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RESULTS))
        else $error("wake count over limit");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_DECIDE) |-> !wr_en)
        else $error("queue write during scan");

    a_woken_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && due) |=> !valid_reg[$past(best_idx_reg)])
        else $error("woken entry still valid");

    a_emit_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> out_v_reg)
        else $error("reply word lost");

endmodule

>>> verif/tb.sv
module tb;
    import tdwq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [1:0]  status;
        logic [31:0] time_value;
        logic        last;
    } reply_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  task_req;
        logic [31:0] ticks;
        logic        has_ref;
        reply_t      ref_reply;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    tick_delay_wakeup_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic [31:0] now_ticks;
    logic [31:0] q_wake [QUEUE_DEPTH];
    logic [7:0]  q_task [QUEUE_DEPTH];
    logic        q_used [QUEUE_DEPTH];

    reply_t replies_due[$];
    int     mismatches;
    int     cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;

    function automatic bit sig_lt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic reply_t mk_reply(logic [7:0] t, logic [1:0] s);
        reply_t r;
        r.task_id    = t;
        r.status     = s;
        r.time_value = now_ticks;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic queue_delay(logic [7:0] t, logic [31:0] wake);
        int i;
        if (sig_lt(now_ticks, wake))
        begin
            for (i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!q_used[i])
                begin
                    q_used[i] = 1'b1;
                    q_wake[i] = wake;
                    q_task[i] = t;
                    return;
                end
            end
            replies_due.push_back(mk_reply(t, ST_FULL));
        end
        else
        begin
            replies_due.push_back(mk_reply(t, (wake == now_ticks) ? ST_OK : ST_PAST));
        end
    endtask

    task automatic predict_word(logic [1:0] cmd, logic [7:0] t, logic [31:0] tk);
        int n;
        int best;
        int i;
        n = 0;
        case (cmd)
            CMD_TICK:
            begin
                now_ticks = now_ticks + 1;
                while (n < MAX_RESULTS)
                begin
                    best = -1;
                    for (i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (q_used[i] && (best < 0 || sig_lt(q_wake[i], q_wake[best]) ||
                            (q_wake[i] == q_wake[best] && q_task[i] < q_task[best])))
                            best = i;
                    end
                    if (best < 0 || sig_lt(now_ticks, q_wake[best]))
                        break;
                    replies_due.push_back(mk_reply(q_task[best], ST_OK));
                    q_used[best] = 1'b0;
                    n++;
                end
            end
            CMD_TIME:
            begin
                replies_due.push_back(mk_reply(t, ST_TIME));
                n = 1;
            end
            CMD_DELAY:
            begin
                i = replies_due.size();
                queue_delay(t, now_ticks + tk);
                n = replies_due.size() - i;
            end
            default:
            begin
                i = replies_due.size();
                queue_delay(t, tk);
                n = replies_due.size() - i;
            end
        endcase
        if (n > 0)
            replies_due[$].last = 1'b1;
    endtask

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.task_id    = m_axis_tdata[7:0];
            got.time_value = m_axis_tdata[39:8];
            got.status     = m_axis_tuser;
            got.last       = m_axis_tlast;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: task %0d st %0d t %h last %0b",
                             got.task_id, got.status, got.time_value, got.last);
            end
            else
            begin
                exp_r = replies_due.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp task %0d st %0d t %h last %0b, ",
                                  "got task %0d st %0d t %h last %0b"},
                                 exp_r.task_id, exp_r.status, exp_r.time_value, exp_r.last,
                                 got.task_id, got.status, got.time_value, got.last);
                end
            end
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [7:0] t, logic [31:0] tk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {tk, t};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_word(cmd, t, tk);
        @(negedge clk);
    endtask

    task automatic random_word();
        logic [1:0]  cmd;
        logic [31:0] tk;
        int r;
        r = $urandom_range(99);
        cmd = (r < 45) ? CMD_TICK : (r < 55) ? CMD_TIME : (r < 80) ? CMD_DELAY : CMD_UNTIL;
        case ($urandom_range(3))
            0: tk = $urandom;
            1: tk = $urandom_range(12);
            2: tk = 32'(-$signed($urandom_range(3)));
            default: tk = now_ticks + $urandom_range(15);
        endcase
        if (cmd == CMD_DELAY && $urandom_range(3) != 0)
            tk = $urandom_range(10);
        send_word(cmd, 8'($urandom), tk);
    endtask

    stim_row_t rows[$];

    task automatic add_row(logic [1:0] c, logic [7:0] t, logic [31:0] tk,
                           logic h, reply_t rr);
        stim_row_t s;
        s.cmd = c;
        s.task_req = t;
        s.ticks = tk;
        s.has_ref = h;
        s.ref_reply = rr;
        rows.push_back(s);
    endtask

    initial
    begin
        int i;
        int k;
        reply_t none;
        none = '0;
        cycles = 0;
        mismatches = 0;
        hold_cycles = 0;
        send_idle_pct = 10;
        recv_idle_pct = 76;
        now_ticks = '0;
        for (i = 0; i < QUEUE_DEPTH; i++)
            q_used[i] = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_TICK;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(CMD_TIME, 8'hff, 32'h0, 1, '{8'hff, ST_TIME, 32'h0, 1'b1});
        add_row(CMD_TICK, 8'h00, 32'h0, 0, none);
        add_row(CMD_UNTIL, 8'h00, 32'h1, 1, '{8'h00, ST_OK, 32'h1, 1'b1});
        add_row(CMD_UNTIL, 8'h12, 32'h80000000, 1, '{8'h12, ST_PAST, 32'h1, 1'b1});
        add_row(CMD_DELAY, 8'h34, 32'h0, 1, '{8'h34, ST_OK, 32'h1, 1'b1});
        add_row(CMD_DELAY, 8'h35, 32'hffffffff, 1, '{8'h35, ST_PAST, 32'h1, 1'b1});
        add_row(CMD_DELAY, 8'h07, 32'h2, 0, none);
        add_row(CMD_DELAY, 8'h03, 32'h2, 0, none);
        add_row(CMD_UNTIL, 8'h03, 32'h3, 0, none);
        add_row(CMD_DELAY, 8'hff, 32'h1, 0, none);
        add_row(CMD_UNTIL, 8'haa, 32'h7fffffff, 0, none);
        add_row(CMD_TICK, 8'h00, 32'hffffffff, 0, none);
        add_row(CMD_TICK, 8'h00, 32'h0, 0, none);
        add_row(CMD_TICK, 8'h00, 32'h0, 0, none);
        for (i = 0; i < rows.size(); i++)
        begin
            send_word(rows[i].cmd, rows[i].task_req, rows[i].ticks);
            if (rows[i].has_ref && replies_due.size() > 0 && replies_due[$] != rows[i].ref_reply)
            begin
                mismatches++;
                $display("predictor disagrees with table row %0d", i);
            end
        end
        // fill the queue, overflow, then wake many in one tick
        for (i = 0; i < QUEUE_DEPTH + 2; i++)
            send_word(CMD_DELAY, 8'(QUEUE_DEPTH - i), 32'd3);
        repeat (3) send_word(CMD_TICK, 8'h00, 32'h0);

        for (k = 0; k < 3; k++)
        begin
            if (k == 1)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 10;
            end
            if (k == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_cycles = 3000;
            end
            for (i = 0; i < 119; i++)
                random_word();
        end
        // queue tasks near the top of the signed tick range
        send_word(CMD_UNTIL, 8'h5a, 32'h7fffffff);
        send_word(CMD_UNTIL, 8'h00, 32'h7ffffffe);
        s_axis_tvalid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
